@@ hw/rtl/sbda_pkg.sv @@
`default_nettype none

package sbda_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// 4-bit bcd adjust threshold for double dabble
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

`default_nettype wire

@@ hw/rtl/signed_binary_to_decimal_ascii.sv @@
// channel  | ports                       | handshake
// ---------+-----------------------------+---------------------------------
// input    | value                       | transfer when start && !busy
// output   | char_code, last             | transfer on each cycle with strobe
//
// one number takes VALUE_WIDTH steps of shift-and-add-3 (one magnitude bit a
// cycle), a step for a minus sign on a negative value, then a step per decimal
// position (leading zeros pass without a strobe); a new value is taken only
// once busy is low, and busy falls at the edge that drives the final character
// arst_n clears the controller; the receiver cannot stall, so no result waits.
`default_nettype none

module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic                               busy,
	output logic                               strobe,
	output logic [7:0]                         char_code,
	output logic                               last
);

	// decimal positions needed for the largest magnitude, 2^(VALUE_WIDTH-1)
	localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   neg_q;
	logic                   started_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic [3:0]             top_digit;
	logic [VALUE_WIDTH-1:0] value_mag;

	assign busy      = (state_q != ST_IDLE);
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign value_mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	// add 3 to every bcd digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= BCD_ADJ_MIN) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + BCD_ADJ_ADD;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe    <= 1'b0;
			last      <= 1'b0;
			char_code <= '0;
			mag_q     <= '0;
			bcd_q     <= '0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_q     <= value_mag;
						neg_q     <= value[VALUE_WIDTH-1];
						bcd_q     <= '0;
						bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
					mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe    <= 1'b1;
					char_code <= CHAR_MINUS;
					last      <= 1'b0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					// the ones digit always goes out, so zero gives '0'
					if (started_q || (top_digit != 4'd0) || (dig_cnt_q == DIG_CNT_W'(1))) begin
						strobe    <= 1'b1;
						char_code <= CHAR_ZERO + {4'd0, top_digit};
						last      <= (dig_cnt_q == DIG_CNT_W'(1));
						started_q <= 1'b1;
					end
					bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - 1'b1;
					if (dig_cnt_q == DIG_CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_last_ends_number: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final character while still busy");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (char_code == CHAR_MINUS) |-> !last)
		else $error("minus sign marked last");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHAR_MINUS) ||
			((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 8'd9)))
		else $error("character out of range");

	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("input transfer did not start a conversion");
`endif

endmodule

`default_nettype wire
